// File: sv/ahwd_pkg.sv
// shared types and constants for the anagram window hash dedup block
package ahwd_pkg;

  localparam logic [29:0] HASH_MOD = 30'd1000000007;
  localparam logic [26:0] FOLD_C   = 27'd73741817;
  localparam logic [7:0]  BASE_A   = 8'd137;
  localparam logic [7:0]  BASE_B   = 8'd139;
  localparam int          ALPHABET = 26;

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] letter;
  } in_t;

  typedef struct packed {
    logic        window_match;
    logic [29:0] hash_first;
    logic [29:0] hash_second;
    logic        first_seen;
    logic [10:0] distinct_total;
    logic        store_full;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [29:0] a;
    logic [7:0]  m;
    logic [4:0]  add;
  } mm_req_t;

  typedef struct packed {
    logic        done;
    logic [29:0] res;
  } mm_rsp_t;

endpackage

// File: sv/anagram_window_hash_dedup.sv
// top level: sequencer, histograms, rolling hashes and distinct pair store
// usage
//   in channel (in_valid/in_ready/in_data) takes one opcode and letter per transaction
//   out channel (out_valid/out_ready/out_data) returns exactly one result per transaction
//   pattern letters run two modular power updates on the shared unit
//   text letters run two modular products, four once the window is full, on the shared
//   multiply-fold unit, then scan up to SEEN_DEPTH stored pairs when the window matches
//   text letters with an empty pattern skip the products but still compare and scan
//   clear, unused opcodes, ignored pattern letters and bad letters go straight to the final step
//   in_ready is high whenever the sequencer is idle, even while a result waits
//   a finished result waits in its final step until the output register is free
//   out_data holds steady while out_valid is high and out_ready is low
//   reset (and the clear opcode) empties histograms, hashes and the pair store and sets powers to one
//   the pair store is emptied by zeroing its fill count, no clearing pass is needed
module anagram_window_hash_dedup #(
  parameter int MAX_PATTERN = 1024,
  parameter int SEEN_DEPTH  = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ahwd_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ahwd_pkg::out_t   out_data
);

  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int RAW = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
  localparam int SCW = $clog2(SEEN_DEPTH + 1);
  localparam int SAW = SEEN_DEPTH > 1 ? $clog2(SEEN_DEPTH) : 1;
  localparam int NA  = ahwd_pkg::ALPHABET;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PWA  = 4'd1;
  localparam logic [3:0] S_PWB  = 4'd2;
  localparam logic [3:0] S_HA   = 4'd3;
  localparam logic [3:0] S_HAS  = 4'd4;
  localparam logic [3:0] S_HB   = 4'd5;
  localparam logic [3:0] S_HBS  = 4'd6;
  localparam logic [3:0] S_HIST = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_SRD  = 4'd9;
  localparam logic [3:0] S_SCMP = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  function automatic logic [29:0] sub_mod(input logic [29:0] v, input logic [29:0] s);
    logic [30:0] t;
    t = (v >= s) ? 31'(v) - 31'(s) : 31'(v) + 31'(ahwd_pkg::HASH_MOD) - 31'(s);
    return t[29:0];
  endfunction

  logic [3:0]     state_r, state_nxt;
  logic [PLW-1:0] phist_r [NA];
  logic [PLW-1:0] phist_nxt [NA];
  logic [PLW-1:0] whist_r [NA];
  logic [PLW-1:0] whist_nxt [NA];
  logic [PLW-1:0] plen_r, plen_nxt;
  logic [PLW-1:0] tpos_r, tpos_nxt;
  logic [RAW-1:0] rp_r, rp_nxt;
  logic [29:0]    ha_r, ha_nxt, hb_r, hb_nxt;
  logic [29:0]    pwa_r, pwa_nxt, pwb_r, pwb_nxt;
  logic [29:0]    tmp_r, tmp_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic [SAW-1:0] idx_r, idx_nxt;
  logic [4:0]     c_r, c_nxt;
  logic           drop_r, drop_nxt;
  logic           match_r, match_nxt, fresh_r, fresh_nxt, full_r, full_nxt;
  logic           ov_r, ov_nxt;
  ahwd_pkg::out_t od_r, od_nxt;

  ahwd_pkg::mm_req_t mm_req;
  ahwd_pkg::mm_rsp_t mm_rsp;

  logic           ring_we;
  logic [4:0]     ring_rdata;
  logic           seen_we;
  logic [59:0]    seen_rdata;
  logic           accept;
  logic           hist_eq;
  logic [4:0]     old_c;

  ahwd_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  ahwd_ram #(.WIDTH(5), .DEPTH(MAX_PATTERN)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (rp_r),
    .wdata (c_r),
    .raddr (rp_r),
    .rdata (ring_rdata)
  );

  ahwd_ram #(.WIDTH(60), .DEPTH(SEEN_DEPTH)) u_seen (
    .clk   (clk),
    .we    (seen_we),
    .waddr (cnt_r[SAW-1:0]),
    .wdata ({ha_r, hb_r}),
    .raddr (idx_r),
    .rdata (seen_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign old_c    = ring_rdata;

  always_comb begin
    hist_eq = 1'b1;
    for (int i = 0; i < NA; i++) begin
      if (phist_r[i] != whist_r[i]) begin
        hist_eq = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    phist_nxt = phist_r;
    whist_nxt = whist_r;
    plen_nxt  = plen_r;
    tpos_nxt  = tpos_r;
    rp_nxt    = rp_r;
    ha_nxt    = ha_r;
    hb_nxt    = hb_r;
    pwa_nxt   = pwa_r;
    pwb_nxt   = pwb_r;
    tmp_nxt   = tmp_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    c_nxt     = c_r;
    drop_nxt  = drop_r;
    match_nxt = match_r;
    fresh_nxt = fresh_r;
    full_nxt  = full_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    mm_req    = '0;
    ring_we   = 1'b0;
    seen_we   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          match_nxt = 1'b0;
          fresh_nxt = 1'b0;
          full_nxt  = 1'b0;
          c_nxt     = in_data.letter;
          drop_nxt  = (tpos_r >= plen_r);
          state_nxt = S_FIN;
          if (in_data.opcode == ahwd_pkg::OP_CLEAR) begin
            for (int i = 0; i < NA; i++) begin
              phist_nxt[i] = '0;
              whist_nxt[i] = '0;
            end
            plen_nxt = '0;
            tpos_nxt = '0;
            rp_nxt   = '0;
            ha_nxt   = '0;
            hb_nxt   = '0;
            pwa_nxt  = 30'd1;
            pwb_nxt  = 30'd1;
            cnt_nxt  = '0;
          end else if (in_data.letter < 5'(NA)) begin
            if (in_data.opcode == ahwd_pkg::OP_PATTERN) begin
              if (tpos_r == '0 && plen_r < PLW'(MAX_PATTERN)) begin
                phist_nxt[in_data.letter] = phist_r[in_data.letter] + 1'b1;
                plen_nxt     = plen_r + 1'b1;
                mm_req.start = 1'b1;
                mm_req.a     = pwa_r;
                mm_req.m     = ahwd_pkg::BASE_A;
                state_nxt    = S_PWA;
              end
            end else if (in_data.opcode == ahwd_pkg::OP_TEXT) begin
              if (plen_r == '0) begin
                ha_nxt    = '0;
                hb_nxt    = '0;
                tpos_nxt  = '0;
                state_nxt = S_CMP;
              end else begin
                mm_req.start = 1'b1;
                mm_req.a     = ha_r;
                mm_req.m     = ahwd_pkg::BASE_A;
                mm_req.add   = in_data.letter;
                state_nxt    = S_HA;
              end
            end
          end
        end
      end
      S_PWA: begin
        if (mm_rsp.done) begin
          pwa_nxt      = mm_rsp.res;
          mm_req.start = 1'b1;
          mm_req.a     = pwb_r;
          mm_req.m     = ahwd_pkg::BASE_B;
          state_nxt    = S_PWB;
        end
      end
      S_PWB: begin
        if (mm_rsp.done) begin
          pwb_nxt   = mm_rsp.res;
          state_nxt = S_FIN;
        end
      end
      S_HA: begin
        if (mm_rsp.done) begin
          mm_req.start = 1'b1;
          if (drop_r) begin
            tmp_nxt   = mm_rsp.res;
            mm_req.a  = pwa_r;
            mm_req.m  = 8'(old_c);
            state_nxt = S_HAS;
          end else begin
            ha_nxt     = mm_rsp.res;
            mm_req.a   = hb_r;
            mm_req.m   = ahwd_pkg::BASE_B;
            mm_req.add = c_r;
            state_nxt  = S_HB;
          end
        end
      end
      S_HAS: begin
        if (mm_rsp.done) begin
          ha_nxt       = sub_mod(tmp_r, mm_rsp.res);
          mm_req.start = 1'b1;
          mm_req.a     = hb_r;
          mm_req.m     = ahwd_pkg::BASE_B;
          mm_req.add   = c_r;
          state_nxt    = S_HB;
        end
      end
      S_HB: begin
        if (mm_rsp.done) begin
          if (drop_r) begin
            tmp_nxt      = mm_rsp.res;
            mm_req.start = 1'b1;
            mm_req.a     = pwb_r;
            mm_req.m     = 8'(old_c);
            state_nxt    = S_HBS;
          end else begin
            hb_nxt    = mm_rsp.res;
            state_nxt = S_HIST;
          end
        end
      end
      S_HBS: begin
        if (mm_rsp.done) begin
          hb_nxt    = sub_mod(tmp_r, mm_rsp.res);
          state_nxt = S_HIST;
        end
      end
      S_HIST: begin
        for (int i = 0; i < NA; i++) begin
          if (5'(i) == c_r) begin
            whist_nxt[i] = whist_r[i] + 1'b1;
          end
          if (drop_r && 5'(i) == old_c && whist_nxt[i] != '0) begin
            whist_nxt[i] = whist_nxt[i] - 1'b1;
          end
        end
        ring_we = 1'b1;
        rp_nxt  = (PLW'(rp_r) + 1'b1 >= plen_r) ? '0 : rp_r + 1'b1;
        if (!drop_r) begin
          tpos_nxt = tpos_r + 1'b1;
        end
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hist_eq) begin
          match_nxt = 1'b1;
          if (cnt_r == '0) begin
            if (SCW'(SEEN_DEPTH) != '0) begin
              seen_we   = 1'b1;
              cnt_nxt   = cnt_r + 1'b1;
              fresh_nxt = 1'b1;
            end
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SRD;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SRD: begin
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (seen_rdata == {ha_r, hb_r}) begin
          state_nxt = S_FIN;
        end else if (SCW'(idx_r) + 1'b1 >= cnt_r) begin
          if (cnt_r < SCW'(SEEN_DEPTH)) begin
            seen_we   = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            fresh_nxt = 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt                = 1'b1;
          od_nxt.window_match   = match_r;
          od_nxt.hash_first     = ha_r;
          od_nxt.hash_second    = hb_r;
          od_nxt.first_seen     = fresh_r;
          od_nxt.distinct_total = 11'(cnt_r);
          od_nxt.store_full     = full_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < NA; i++) begin
        phist_r[i] <= '0;
        whist_r[i] <= '0;
      end
      plen_r <= '0;
      tpos_r <= '0;
      rp_r   <= '0;
      ha_r   <= '0;
      hb_r   <= '0;
      pwa_r  <= 30'd1;
      pwb_r  <= 30'd1;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phist_r <= phist_nxt;
      whist_r <= whist_nxt;
      plen_r  <= plen_nxt;
      tpos_r  <= tpos_nxt;
      rp_r    <= rp_nxt;
      ha_r    <= ha_nxt;
      hb_r    <= hb_nxt;
      pwa_r   <= pwa_nxt;
      pwb_r   <= pwb_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    tmp_r   <= tmp_nxt;
    idx_r   <= idx_nxt;
    c_r     <= c_nxt;
    drop_r  <= drop_nxt;
    match_r <= match_nxt;
    fresh_r <= fresh_nxt;
    full_r  <= full_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: sv/ahwd_ram.sv
// generic single-write, registered-read memory
module ahwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/ahwd_mulmod.sv
// iterative (a * m + add) mod 1e9+7 unit, one fold per cycle
module ahwd_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  ahwd_pkg::mm_req_t req,
  output ahwd_pkg::mm_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [37:0] x_r, x_nxt;
  logic [29:0] res_r, res_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    res_nxt  = res_r;
    if (req.start) begin
      x_nxt    = 38'(req.a) * 38'(req.m) + 38'(req.add);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r[37:30] != 8'd0) begin
        x_nxt = 38'(x_r[37:30]) * 38'(ahwd_pkg::FOLD_C) + 38'(x_r[29:0]);
      end else begin
        res_nxt  = (x_r[29:0] >= ahwd_pkg::HASH_MOD) ?
                   x_r[29:0] - ahwd_pkg::HASH_MOD : x_r[29:0];
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r   <= x_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// File: sv/ahwd_checker.sv
// port-level checks for the anagram window hash dedup block, with bind
module ahwd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ahwd_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ahwd_pkg::out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fresh_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.first_seen |-> out_data.window_match)
    else $error("new pair without a window match");

  a_full_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_full |-> out_data.window_match && !out_data.first_seen)
    else $error("store full flag without a match or with an insert");

  // accepted clear empties the store in its result
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == ahwd_pkg::OP_CLEAR && !out_valid
      |=> ##1 out_valid && out_data.distinct_total == 11'd0 && !out_data.window_match)
    else $error("clear result not empty");

endmodule

bind anagram_window_hash_dedup ahwd_checker u_ahwd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
